// ===== rtl/core/hcp_pkg.sv =====
// Shared types, codes and helper functions of the HTTP chunked response parser.
package hcp_pkg;

  // Parse phases.
  localparam logic [3:0] PH_IDLE      = 4'd0;
  localparam logic [3:0] PH_STATUS    = 4'd1;
  localparam logic [3:0] PH_STATUS_CR = 4'd2;
  localparam logic [3:0] PH_HDR       = 4'd3;
  localparam logic [3:0] PH_HDR_CR    = 4'd4;
  localparam logic [3:0] PH_SIZE      = 4'd5;
  localparam logic [3:0] PH_SIZE_CR   = 4'd6;
  localparam logic [3:0] PH_CHUNK     = 4'd7;
  localparam logic [3:0] PH_DONE      = 4'd8;

  // Status code decoding phases.
  localparam logic [1:0] CODE_WAIT_SP = 2'd0;
  localparam logic [1:0] CODE_DIGITS  = 2'd1;
  localparam logic [1:0] CODE_OVER    = 2'd2;

  // Result kinds.
  localparam logic [2:0] KIND_STATUS_BYTE = 3'd0;
  localparam logic [2:0] KIND_STATUS_END  = 3'd1;
  localparam logic [2:0] KIND_HDR_BYTE    = 3'd2;
  localparam logic [2:0] KIND_HDR_END     = 3'd3;
  localparam logic [2:0] KIND_HDRS_DONE   = 3'd4;
  localparam logic [2:0] KIND_CHUNK_BYTE  = 3'd5;
  localparam logic [2:0] KIND_COMPLETE    = 3'd6;
  localparam logic [2:0] KIND_SIZE_ERR    = 3'd7;

  // Characters.
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_SP = 8'h20;
  localparam logic [7:0] CH_0  = 8'h30;
  localparam logic [7:0] CH_9  = 8'h39;
  localparam logic [7:0] CH_LA = 8'h61;
  localparam logic [7:0] CH_LF_HEX = 8'h66;
  localparam logic [7:0] CH_UA = 8'h41;
  localparam logic [7:0] CH_UF = 8'h46;

  localparam logic [9:0] CODE_MAX = 10'd999;

  // Result queue geometry.
  localparam int RES_DEPTH = 4;
  localparam int RES_PTR_W = 2;
  localparam int RES_CNT_W = 3;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] out_byte;
    logic [9:0] status_code;
    logic       chunk_end;
    logic       last_of_run;
  } result_t;

  typedef struct packed {
    logic [9:0] value;
    logic [1:0] phase;
  } code_t;

  typedef struct packed {
    logic [3:0] phase;
    code_t      code;
    logic       line_nonempty;
  } ctx_t;

  // Status code tracking for one status-line character.
  function automatic code_t status_upd(code_t cur, logic [7:0] c);
    code_t       nxt;
    logic [13:0] acc;
    nxt = cur;
    acc = {1'b0, cur.value, 3'b000} + {3'b000, cur.value, 1'b0} + {10'd0, c[3:0]};
    if (cur.phase == CODE_WAIT_SP) begin
      if (c == CH_SP) nxt.phase = CODE_DIGITS;
    end else if (cur.phase == CODE_DIGITS) begin
      if (c >= CH_0 && c <= CH_9) begin
        nxt.value = (acc > {4'd0, CODE_MAX}) ? CODE_MAX : acc[9:0];
      end else begin
        nxt.phase = CODE_OVER;
      end
    end
    return nxt;
  endfunction

  function automatic result_t mk_res(logic [2:0] kind, logic [7:0] b, logic [9:0] code,
                                     logic cend);
    result_t r;
    r.kind        = kind;
    r.out_byte    = b;
    r.status_code = code;
    r.chunk_end   = cend;
    r.last_of_run = 1'b0;
    return r;
  endfunction

endpackage

// ===== rtl/core/http_response_chunked_parser_unit.sv =====
// Top level of the HTTP chunked response parser.
//
// Input channel: in_valid_i/in_ready_o carry one item per transfer: op_i = 0
// starts a new response, op_i = 1 delivers one received byte in data_value_i.
// Output channel: out_valid_o/out_ready_i carry one result per transfer; an
// item gives zero, one or two results, and last_of_run_o marks the last one.
// cfg_we_i writes cfg_wdata_i to the chunk size radix (0 decimal, 1 hex).
// An accepted item is held in the input register while the step logic works
// on it; its results are written into the result queue once the queue has
// room, and output valid is taken from the registered queue count.
// Throughput is one item per cycle as long as results are taken; an item
// with two results needs two output transfers, so a run of such items slows
// the input once the four-entry result queue fills. The queue's free space
// gates processing, so when the receiver stalls the input register and then
// in_ready_o hold off new transfers.
// Reset clears the parse state to idle, empties the queue and sets the radix
// to decimal; bytes before the first begin item give no results.
module http_response_chunked_parser_unit #(
  parameter int CHUNK_LEN_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       op_i,
  input  logic [7:0] data_value_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] kind_o,
  output logic [7:0] out_byte_o,
  output logic [9:0] status_code_o,
  output logic       chunk_end_o,
  output logic       last_of_run_o
);

  logic                      radix_q;
  logic                      in_vld_q;
  logic                      op_q;
  logic [7:0]                data_q;
  hcp_pkg::ctx_t             ctx_q, ctx_d;
  logic [CHUNK_LEN_BITS-1:0] size_q, size_d;
  logic [CHUNK_LEN_BITS-1:0] count_q, count_d;
  logic [1:0]                res_n;
  hcp_pkg::result_t          res0, res1, head;
  logic                      room;
  logic                      fire;
  logic                      in_xfer;

  assign fire       = in_vld_q && room;
  assign in_ready_o = !in_vld_q || fire;
  assign in_xfer    = in_valid_i && in_ready_o;

  hcp_step #(
    .CHUNK_LEN_BITS(CHUNK_LEN_BITS)
  ) u_step (
    .op_i    (op_q),
    .data_i  (data_q),
    .radix_i (radix_q),
    .ctx_i   (ctx_q),
    .size_i  (size_q),
    .count_i (count_q),
    .ctx_o   (ctx_d),
    .size_o  (size_d),
    .count_o (count_d),
    .res_n_o (res_n),
    .res0_o  (res0),
    .res1_o  (res1)
  );

  hcp_resq u_resq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_n_i    (fire ? res_n : 2'd0),
    .push0_i     (res0),
    .push1_i     (res1),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (head)
  );

  assign kind_o        = head.kind;
  assign out_byte_o    = head.out_byte;
  assign status_code_o = head.status_code;
  assign chunk_end_o   = head.chunk_end;
  assign last_of_run_o = head.last_of_run;

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q   <= op_i;
      data_q <= data_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q                <= 1'b0;
      in_vld_q               <= 1'b0;
      ctx_q.phase            <= hcp_pkg::PH_IDLE;
      ctx_q.code.value       <= '0;
      ctx_q.code.phase       <= hcp_pkg::CODE_WAIT_SP;
      ctx_q.line_nonempty    <= 1'b0;
      size_q                 <= '0;
      count_q                <= '0;
    end else begin
      if (cfg_we_i) begin
        radix_q <= cfg_wdata_i;
      end
      if (in_xfer) begin
        in_vld_q <= 1'b1;
      end else if (fire) begin
        in_vld_q <= 1'b0;
      end
      if (fire) begin
        ctx_q   <= ctx_d;
        size_q  <= size_d;
        count_q <= count_d;
      end
    end
  end

endmodule

// ===== rtl/core/hcp_step.sv =====
// Next-state and result logic for one parser input item.
module hcp_step #(
  parameter int CHUNK_LEN_BITS = 16
) (
  input  logic                      op_i,
  input  logic [7:0]                data_i,
  input  logic                      radix_i,
  input  hcp_pkg::ctx_t             ctx_i,
  input  logic [CHUNK_LEN_BITS-1:0] size_i,
  input  logic [CHUNK_LEN_BITS-1:0] count_i,
  output hcp_pkg::ctx_t             ctx_o,
  output logic [CHUNK_LEN_BITS-1:0] size_o,
  output logic [CHUNK_LEN_BITS-1:0] count_o,
  output logic [1:0]                res_n_o,
  output hcp_pkg::result_t          res0_o,
  output hcp_pkg::result_t          res1_o
);

  localparam int W = CHUNK_LEN_BITS;

  hcp_pkg::code_t   code_a;
  hcp_pkg::code_t   code_cr;
  hcp_pkg::code_t   code_b;
  hcp_pkg::result_t r0;
  hcp_pkg::result_t r1;
  logic [1:0]       n;

  logic             dig_ok;
  logic [3:0]       dig;
  logic [W+3:0]     size_scaled;
  logic [W+3:0]     size_acc;
  logic [W-1:0]     size_next;
  logic [W-1:0]     count_inc;

  // Size digit decode and accumulate.
  always_comb begin
    dig_ok = 1'b0;
    dig    = 4'd0;
    if (data_i >= hcp_pkg::CH_0 && data_i <= hcp_pkg::CH_9) begin
      dig_ok = 1'b1;
      dig    = data_i[3:0];
    end else if (radix_i && data_i >= hcp_pkg::CH_LA && data_i <= hcp_pkg::CH_LF_HEX) begin
      dig_ok = 1'b1;
      dig    = data_i[3:0] + 4'd9;
    end else if (radix_i && data_i >= hcp_pkg::CH_UA && data_i <= hcp_pkg::CH_UF) begin
      dig_ok = 1'b1;
      dig    = data_i[3:0] + 4'd9;
    end
    if (radix_i) begin
      size_scaled = {size_i, 4'b0000};
    end else begin
      size_scaled = {1'b0, size_i, 3'b000} + {3'b000, size_i, 1'b0};
    end
    size_acc  = size_scaled + {{W{1'b0}}, dig};
    size_next = (size_acc[W+3:W] != 4'd0) ? {W{1'b1}} : size_acc[W-1:0];
    count_inc = count_i + {{(W-1){1'b0}}, 1'b1};
  end

  always_comb begin
    ctx_o   = ctx_i;
    size_o  = size_i;
    count_o = count_i;
    n       = 2'd0;
    r0      = '0;
    r1      = '0;
    code_a  = hcp_pkg::status_upd(ctx_i.code, data_i);
    code_cr = hcp_pkg::status_upd(ctx_i.code, hcp_pkg::CH_CR);
    code_b  = hcp_pkg::status_upd(code_cr, data_i);

    if (!op_i) begin
      ctx_o.phase         = hcp_pkg::PH_STATUS;
      ctx_o.code.value    = '0;
      ctx_o.code.phase    = hcp_pkg::CODE_WAIT_SP;
      ctx_o.line_nonempty = 1'b0;
      size_o              = '0;
      count_o             = '0;
    end else begin
      unique case (ctx_i.phase)
        hcp_pkg::PH_STATUS: begin
          if (data_i == hcp_pkg::CH_CR) begin
            ctx_o.phase = hcp_pkg::PH_STATUS_CR;
          end else begin
            ctx_o.code = code_a;
            n  = 2'd1;
            r0 = hcp_pkg::mk_res(hcp_pkg::KIND_STATUS_BYTE, data_i, code_a.value, 1'b0);
          end
        end
        hcp_pkg::PH_STATUS_CR: begin
          if (data_i == hcp_pkg::CH_LF) begin
            n  = 2'd1;
            r0 = hcp_pkg::mk_res(hcp_pkg::KIND_STATUS_END, 8'd0, ctx_i.code.value, 1'b0);
            size_o              = '0;
            ctx_o.line_nonempty = 1'b0;
            ctx_o.phase         = hcp_pkg::PH_HDR;
          end else begin
            // The CR was not a line end: both bytes belong to the status line.
            ctx_o.code  = code_b;
            ctx_o.phase = hcp_pkg::PH_STATUS;
            n  = 2'd2;
            r0 = hcp_pkg::mk_res(hcp_pkg::KIND_STATUS_BYTE, hcp_pkg::CH_CR,
                                 code_cr.value, 1'b0);
            r1 = hcp_pkg::mk_res(hcp_pkg::KIND_STATUS_BYTE, data_i, code_b.value, 1'b0);
          end
        end
        hcp_pkg::PH_HDR: begin
          if (data_i == hcp_pkg::CH_CR) begin
            ctx_o.phase = hcp_pkg::PH_HDR_CR;
          end else begin
            ctx_o.line_nonempty = 1'b1;
            n  = 2'd1;
            r0 = hcp_pkg::mk_res(hcp_pkg::KIND_HDR_BYTE, data_i, ctx_i.code.value, 1'b0);
          end
        end
        hcp_pkg::PH_HDR_CR: begin
          if (data_i == hcp_pkg::CH_LF) begin
            n = 2'd1;
            if (!ctx_i.line_nonempty) begin
              r0 = hcp_pkg::mk_res(hcp_pkg::KIND_HDRS_DONE, 8'd0, ctx_i.code.value, 1'b0);
              size_o      = '0;
              ctx_o.phase = hcp_pkg::PH_SIZE;
            end else begin
              r0 = hcp_pkg::mk_res(hcp_pkg::KIND_HDR_END, 8'd0, ctx_i.code.value, 1'b0);
              ctx_o.phase = hcp_pkg::PH_HDR;
            end
            ctx_o.line_nonempty = 1'b0;
          end else begin
            ctx_o.line_nonempty = 1'b1;
            ctx_o.phase         = hcp_pkg::PH_HDR;
            n  = 2'd2;
            r0 = hcp_pkg::mk_res(hcp_pkg::KIND_HDR_BYTE, hcp_pkg::CH_CR, ctx_i.code.value,
                                 1'b0);
            r1 = hcp_pkg::mk_res(hcp_pkg::KIND_HDR_BYTE, data_i, ctx_i.code.value, 1'b0);
          end
        end
        hcp_pkg::PH_SIZE: begin
          if (data_i == hcp_pkg::CH_CR) begin
            ctx_o.phase = hcp_pkg::PH_SIZE_CR;
          end else if (dig_ok) begin
            size_o = size_next;
          end
        end
        hcp_pkg::PH_SIZE_CR: begin
          if (data_i == hcp_pkg::CH_LF) begin
            if (size_i != '0) begin
              count_o     = '0;
              ctx_o.phase = hcp_pkg::PH_CHUNK;
            end else begin
              n  = 2'd1;
              r0 = hcp_pkg::mk_res(hcp_pkg::KIND_COMPLETE, 8'd0, ctx_i.code.value, 1'b0);
              ctx_o.phase = hcp_pkg::PH_DONE;
            end
          end else begin
            n  = 2'd1;
            r0 = hcp_pkg::mk_res(hcp_pkg::KIND_SIZE_ERR, 8'd0, ctx_i.code.value, 1'b0);
          end
        end
        hcp_pkg::PH_CHUNK: begin
          n = 2'd1;
          if (count_inc == size_i) begin
            r0 = hcp_pkg::mk_res(hcp_pkg::KIND_CHUNK_BYTE, data_i, ctx_i.code.value, 1'b1);
            size_o      = '0;
            count_o     = '0;
            ctx_o.phase = hcp_pkg::PH_SIZE;
          end else begin
            r0 = hcp_pkg::mk_res(hcp_pkg::KIND_CHUNK_BYTE, data_i, ctx_i.code.value, 1'b0);
            count_o = count_inc;
          end
        end
        default: begin
        end
      endcase
    end

    if (n == 2'd2) begin
      r1.last_of_run = 1'b1;
    end else begin
      r0.last_of_run = 1'b1;
    end
  end

  assign res_n_o = n;
  assign res0_o  = r0;
  assign res1_o  = r1;

endmodule

// ===== rtl/core/hcp_resq.sv =====
// Small result queue that takes up to two results per cycle and gives one.
module hcp_resq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [1:0]       push_n_i,
  input  hcp_pkg::result_t push0_i,
  input  hcp_pkg::result_t push1_i,
  output logic             room_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output hcp_pkg::result_t out_o
);

  localparam int PW = hcp_pkg::RES_PTR_W;
  localparam int CW = hcp_pkg::RES_CNT_W;

  hcp_pkg::result_t                 mem_q [hcp_pkg::RES_DEPTH];
  logic [hcp_pkg::RES_PTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [hcp_pkg::RES_PTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [hcp_pkg::RES_CNT_W-1:0]    cnt_q, cnt_d;
  logic                             pop;
  logic [hcp_pkg::RES_PTR_W-1:0]    wr_ptr_p1;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_o       = mem_q[rd_ptr_q];
  // Leave room for the worst case of two results from one item.
  assign room_o      = (cnt_q <= CW'(hcp_pkg::RES_DEPTH - 2));
  assign wr_ptr_p1   = wr_ptr_q + 1'b1;

  always_comb begin
    wr_ptr_d = wr_ptr_q + PW'(push_n_i);
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + CW'(push_n_i) - CW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      mem_q[wr_ptr_q] <= push0_i;
    end
    if (push_n_i == 2'd2) begin
      mem_q[wr_ptr_p1] <= push1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// ===== tb/http_response_chunked_parser_unit_tb.sv =====
// Self-checking testbench for the HTTP chunked response parser unit.
module http_response_chunked_parser_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     LEN_BITS      = 16;
  localparam longint SIZE_MAX      = (64'd1 << LEN_BITS) - 1;
  localparam int     CYCLE_LIMIT   = 500000;
  localparam int     SETTLE_CYCLES = 8;
  localparam int     HOLD_CYCLES   = 400;

  typedef struct {
    logic             op;
    logic [7:0]       data;
    bit               typed;
    bit               has_res;
    hcp_pkg::result_t res;
  } dir_row_t;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic       cfg_wdata_i;
  logic       in_valid_i;
  logic       in_ready_o;
  logic       op_i;
  logic [7:0] data_value_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [2:0] kind_o;
  logic [7:0] out_byte_o;
  logic [9:0] status_code_o;
  logic       chunk_end_o;
  logic       last_of_run_o;

  // Behavioral copy of the parser state and the radix register.
  logic [3:0]          ps_phase;
  logic [9:0]          ps_code;
  logic [1:0]          ps_code_ph;
  bit                  ps_line;
  logic [LEN_BITS-1:0] ps_size;
  logic [LEN_BITS-1:0] ps_count;
  bit                  ps_radix;

  hcp_pkg::result_t step_results[$];
  hcp_pkg::result_t due_results[$];
  dir_row_t         dir_rows[$];
  hcp_pkg::result_t mon_got;
  hcp_pkg::result_t mon_want;
  int               err_cnt = 0;
  int               live_items = 0;
  int               cycle_cnt = 0;
  bit               tx_steady;
  bit               hold_req = 1'b0;

  http_response_chunked_parser_unit #(
    .CHUNK_LEN_BITS(LEN_BITS)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .data_value_i (data_value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind_o),
    .out_byte_o   (out_byte_o),
    .status_code_o(status_code_o),
    .chunk_end_o  (chunk_end_o),
    .last_of_run_o(last_of_run_o)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("** http_response_chunked_parser_unit: FAILED **");
    $finish;
  end

  function automatic hcp_pkg::result_t res_of(logic [2:0] k, logic [7:0] b,
                                              logic [9:0] code, logic cend);
    hcp_pkg::result_t r;
    r.kind        = k;
    r.out_byte    = b;
    r.status_code = code;
    r.chunk_end   = cend;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  function automatic void note_result(logic [2:0] k, logic [7:0] b, logic cend);
    step_results = {step_results, res_of(k, b, ps_code, cend)};
  endfunction

  function automatic void status_byte(logic [7:0] c);
    int acc;
    if (ps_code_ph == hcp_pkg::CODE_WAIT_SP) begin
      if (c == hcp_pkg::CH_SP) ps_code_ph = hcp_pkg::CODE_DIGITS;
    end else if (ps_code_ph == hcp_pkg::CODE_DIGITS) begin
      if (c >= hcp_pkg::CH_0 && c <= hcp_pkg::CH_9) begin
        acc = ps_code * 10 + (c - hcp_pkg::CH_0);
        ps_code = (acc > hcp_pkg::CODE_MAX) ? hcp_pkg::CODE_MAX : acc[9:0];
      end else begin
        ps_code_ph = hcp_pkg::CODE_OVER;
      end
    end
    note_result(hcp_pkg::KIND_STATUS_BYTE, c, 1'b0);
  endfunction

  function automatic void size_digit(logic [7:0] c);
    int     d;
    longint v;
    d = -1;
    if (c >= hcp_pkg::CH_0 && c <= hcp_pkg::CH_9) begin
      d = int'(c - hcp_pkg::CH_0);
    end else if (ps_radix && c >= hcp_pkg::CH_LA && c <= hcp_pkg::CH_LF_HEX) begin
      d = int'(c - hcp_pkg::CH_LA) + 10;
    end else if (ps_radix && c >= hcp_pkg::CH_UA && c <= hcp_pkg::CH_UF) begin
      d = int'(c - hcp_pkg::CH_UA) + 10;
    end
    if (d >= 0) begin
      v = longint'(ps_size) * (ps_radix ? 16 : 10) + d;
      ps_size = (v > SIZE_MAX) ? SIZE_MAX[LEN_BITS-1:0] : v[LEN_BITS-1:0];
    end
  endfunction

  // Computes the results of one item into step_results and advances the state.
  function automatic void parse_step(logic op, logic [7:0] c);
    hcp_pkg::result_t r;
    step_results.delete();
    if (op == 1'b0) begin
      ps_phase   = hcp_pkg::PH_STATUS;
      ps_code    = '0;
      ps_code_ph = hcp_pkg::CODE_WAIT_SP;
      ps_line    = 1'b0;
      ps_size    = '0;
      ps_count   = '0;
    end else begin
      case (ps_phase)
        hcp_pkg::PH_STATUS: begin
          if (c == hcp_pkg::CH_CR) ps_phase = hcp_pkg::PH_STATUS_CR;
          else status_byte(c);
        end
        hcp_pkg::PH_STATUS_CR: begin
          if (c == hcp_pkg::CH_LF) begin
            note_result(hcp_pkg::KIND_STATUS_END, 8'h00, 1'b0);
            ps_size  = '0;
            ps_line  = 1'b0;
            ps_phase = hcp_pkg::PH_HDR;
          end else begin
            status_byte(hcp_pkg::CH_CR);
            status_byte(c);
            ps_phase = hcp_pkg::PH_STATUS;
          end
        end
        hcp_pkg::PH_HDR: begin
          if (c == hcp_pkg::CH_CR) begin
            ps_phase = hcp_pkg::PH_HDR_CR;
          end else begin
            ps_line = 1'b1;
            note_result(hcp_pkg::KIND_HDR_BYTE, c, 1'b0);
          end
        end
        hcp_pkg::PH_HDR_CR: begin
          if (c == hcp_pkg::CH_LF) begin
            if (!ps_line) begin
              note_result(hcp_pkg::KIND_HDRS_DONE, 8'h00, 1'b0);
              ps_size  = '0;
              ps_phase = hcp_pkg::PH_SIZE;
            end else begin
              note_result(hcp_pkg::KIND_HDR_END, 8'h00, 1'b0);
              ps_phase = hcp_pkg::PH_HDR;
            end
            ps_line = 1'b0;
          end else begin
            ps_line = 1'b1;
            note_result(hcp_pkg::KIND_HDR_BYTE, hcp_pkg::CH_CR, 1'b0);
            note_result(hcp_pkg::KIND_HDR_BYTE, c, 1'b0);
            ps_phase = hcp_pkg::PH_HDR;
          end
        end
        hcp_pkg::PH_SIZE: begin
          if (c == hcp_pkg::CH_CR) ps_phase = hcp_pkg::PH_SIZE_CR;
          else size_digit(c);
        end
        hcp_pkg::PH_SIZE_CR: begin
          if (c == hcp_pkg::CH_LF) begin
            if (ps_size != '0) begin
              ps_count = '0;
              ps_phase = hcp_pkg::PH_CHUNK;
            end else begin
              note_result(hcp_pkg::KIND_COMPLETE, 8'h00, 1'b0);
              ps_phase = hcp_pkg::PH_DONE;
            end
          end else begin
            note_result(hcp_pkg::KIND_SIZE_ERR, 8'h00, 1'b0);
          end
        end
        hcp_pkg::PH_CHUNK: begin
          ps_count = ps_count + 1'b1;
          if (ps_count == ps_size) begin
            note_result(hcp_pkg::KIND_CHUNK_BYTE, c, 1'b1);
            ps_size  = '0;
            ps_count = '0;
            ps_phase = hcp_pkg::PH_SIZE;
          end else begin
            note_result(hcp_pkg::KIND_CHUNK_BYTE, c, 1'b0);
          end
        end
        default: begin
        end
      endcase
    end
    if (step_results.size() > 0) begin
      r = step_results[step_results.size() - 1];
      r.last_of_run = 1'b1;
      step_results[step_results.size() - 1] = r;
    end
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic dir_row_t row(logic op, logic [7:0] d);
    dir_row_t x;
    x.op      = op;
    x.data    = d;
    x.typed   = 1'b0;
    x.has_res = 1'b0;
    x.res     = '0;
    return x;
  endfunction

  function automatic dir_row_t trow(logic op, logic [7:0] d, bit has, logic [2:0] k,
                                    logic [7:0] b, logic [9:0] code, logic cend);
    dir_row_t x;
    x.op      = op;
    x.data    = d;
    x.typed   = 1'b1;
    x.has_res = has;
    x.res     = res_of(k, b, code, cend);
    x.res.last_of_run = 1'b1;
    return x;
  endfunction

  function automatic void add_row(dir_row_t x);
    dir_rows = {dir_rows, x};
  endfunction

  // Offers one item, waits for its transfer and records what it should cause.
  task automatic put_item(input logic op, input logic [7:0] d, input bit typed,
                          input bit has_res, input hcp_pkg::result_t t_res);
    logic [3:0] ph_before;
    @(negedge clk_i);
    in_valid_i   = 1'b1;
    op_i         = op;
    data_value_i = d;
    forever begin
      @(posedge clk_i);
      if (in_ready_o) break;
    end
    ph_before = ps_phase;
    parse_step(op, d);
    if (typed) begin
      step_results.delete();
      if (has_res) step_results = {step_results, t_res};
    end
    due_results = {due_results, step_results};
    if (op == 1'b0 || !(ph_before inside {hcp_pkg::PH_IDLE, hcp_pkg::PH_DONE})) live_items++;
    if (!tx_steady && $urandom_range(0, 3) == 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (gap_len() - 1) @(negedge clk_i);
    end
  endtask

  task automatic send(input logic op, input logic [7:0] d);
    put_item(op, d, 1'b0, 1'b0, '0);
  endtask

  task automatic wait_all_delivered();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_radix(input bit v);
    wait_all_delivered();
    // Items that give no result may still be in the pipeline.
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    ps_radix = v;
  endtask

  // One line character; now and then a CR that is not followed by LF.
  task automatic send_text();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 7) == 0) begin
      send(1'b1, hcp_pkg::CH_CR);
      if (b == hcp_pkg::CH_LF) b = "x";
      send(1'b1, b);
    end else begin
      if (b == hcp_pkg::CH_CR) b = "y";
      send(1'b1, b);
    end
  endtask

  task automatic send_size(input longint sz);
    logic [7:0] digs[$];
    logic [7:0] b;
    int         base;
    int         d;
    base = ps_radix ? 16 : 10;
    if (sz == 0) digs.push_front(hcp_pkg::CH_0);
    while (sz > 0) begin
      d = int'(sz % base);
      if (d < 10) b = 8'(hcp_pkg::CH_0 + d);
      else b = 8'(($urandom_range(0, 1) ? hcp_pkg::CH_LA : hcp_pkg::CH_UA) + d - 10);
      digs.push_front(b);
      sz = sz / base;
    end
    if ($urandom_range(0, 4) == 0) digs.push_front(hcp_pkg::CH_0);
    foreach (digs[i]) begin
      if ($urandom_range(0, 6) == 0) begin
        case ($urandom_range(0, 3))
          0: send(1'b1, ";");
          1: send(1'b1, "g");
          2: send(1'b1, " ");
          default: send(1'b1, ps_radix ? "z" : "B");
        endcase
      end
      send(1'b1, digs[i]);
    end
    send(1'b1, hcp_pkg::CH_CR);
    if ($urandom_range(0, 9) == 0) begin
      b = 8'($urandom_range(0, 255));
      if (b == hcp_pkg::CH_LF) b = "e";
      send(1'b1, b);
    end
    send(1'b1, hcp_pkg::CH_LF);
  endtask

  task automatic send_response();
    int sz;
    tx_steady = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 4))
        send(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    end
    send(1'b0, 8'($urandom_range(0, 255)));
    repeat ($urandom_range(0, 4)) send_text();
    send(1'b1, hcp_pkg::CH_SP);
    repeat ($urandom_range(0, 5)) send(1'b1, 8'(hcp_pkg::CH_0 + $urandom_range(0, 9)));
    repeat ($urandom_range(0, 4)) send_text();
    send(1'b1, hcp_pkg::CH_CR);
    send(1'b1, hcp_pkg::CH_LF);
    repeat ($urandom_range(0, 3)) begin
      repeat ($urandom_range(1, 6)) send_text();
      send(1'b1, hcp_pkg::CH_CR);
      send(1'b1, hcp_pkg::CH_LF);
    end
    send(1'b1, hcp_pkg::CH_CR);
    send(1'b1, hcp_pkg::CH_LF);
    // A saturated size is never counted out; the response is dropped early.
    if ($urandom_range(0, 9) == 0) begin
      send_size($urandom_range(65536, 999999));
      repeat ($urandom_range(1, 5)) send(1'b1, 8'($urandom_range(0, 255)));
      return;
    end
    repeat ($urandom_range(0, 3)) begin
      sz = int'(($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8));
      send_size(sz);
      repeat (sz) send(1'b1, 8'($urandom_range(0, 255)));
    end
    send_size(0);
    if ($urandom_range(0, 2) == 0) begin
      repeat ($urandom_range(1, 3)) send(1'b1, 8'($urandom_range(0, 255)));
    end
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int rx_run;
    int rx_stall;
    int held;
    rx_run      = 0;
    rx_stall    = 0;
    out_ready_i = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready_i = 1'b0;
        held = 0;
        while (held < HOLD_CYCLES) begin
          @(negedge clk_i);
          held++;
        end
        hold_req = 1'b0;
      end else if (rx_run > 0) begin
        out_ready_i = 1'b1;
        rx_run--;
      end else if (rx_stall > 0) begin
        out_ready_i = 1'b0;
        rx_stall--;
      end else begin
        rx_run   = $urandom_range(1, 30);
        rx_stall = gap_len();
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      mon_got.kind        = kind_o;
      mon_got.out_byte    = out_byte_o;
      mon_got.status_code = status_code_o;
      mon_got.chunk_end   = chunk_end_o;
      mon_got.last_of_run = last_of_run_o;
      if (due_results.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("unexpected result: kind %0d byte %02h code %0d end %0b last %0b",
                   mon_got.kind, mon_got.out_byte, mon_got.status_code,
                   mon_got.chunk_end, mon_got.last_of_run);
      end else begin
        mon_want = due_results.pop_front();
        if (mon_got !== mon_want) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display({"result mismatch: expected kind %0d byte %02h code %0d end %0b ",
                      "last %0b, got kind %0d byte %02h code %0d end %0b last %0b"},
                     mon_want.kind, mon_want.out_byte, mon_want.status_code,
                     mon_want.chunk_end, mon_want.last_of_run, mon_got.kind,
                     mon_got.out_byte, mon_got.status_code, mon_got.chunk_end,
                     mon_got.last_of_run);
        end
      end
    end
  end

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = 1'b0;
    in_valid_i   = 1'b0;
    op_i         = 1'b0;
    data_value_i = 8'h00;
    tx_steady    = 1'b0;
    ps_phase     = hcp_pkg::PH_IDLE;
    ps_code      = '0;
    ps_code_ph   = hcp_pkg::CODE_WAIT_SP;
    ps_line      = 1'b0;
    ps_size      = '0;
    ps_count     = '0;
    ps_radix     = 1'b0;

    // A byte before any begin item is dropped.
    add_row(trow(1'b1, 8'hFF, 1'b0, hcp_pkg::KIND_STATUS_BYTE, 8'h00, 10'd0, 1'b0));
    add_row(trow(1'b0, 8'h00, 1'b0, hcp_pkg::KIND_STATUS_BYTE, 8'h00, 10'd0, 1'b0));
    add_row(trow(1'b1, "A", 1'b1, hcp_pkg::KIND_STATUS_BYTE, "A", 10'd0, 1'b0));
    add_row(row(1'b1, " "));
    add_row(row(1'b1, "9"));
    add_row(row(1'b1, "9"));
    add_row(row(1'b1, "9"));
    // The fourth digit saturates the status code.
    add_row(trow(1'b1, "9", 1'b1, hcp_pkg::KIND_STATUS_BYTE, "9", hcp_pkg::CODE_MAX, 1'b0));
    add_row(trow(1'b1, hcp_pkg::CH_CR, 1'b0, hcp_pkg::KIND_STATUS_BYTE, 8'h00, 10'd0, 1'b0));
    add_row(row(1'b1, "x"));
    add_row(row(1'b1, hcp_pkg::CH_CR));
    add_row(trow(1'b1, hcp_pkg::CH_LF, 1'b1, hcp_pkg::KIND_STATUS_END, 8'h00,
                 hcp_pkg::CODE_MAX, 1'b0));
    add_row(trow(1'b1, 8'h00, 1'b1, hcp_pkg::KIND_HDR_BYTE, 8'h00, hcp_pkg::CODE_MAX, 1'b0));
    add_row(row(1'b1, hcp_pkg::CH_CR));
    add_row(row(1'b1, 8'hFF));
    add_row(row(1'b1, hcp_pkg::CH_CR));
    add_row(trow(1'b1, hcp_pkg::CH_LF, 1'b1, hcp_pkg::KIND_HDR_END, 8'h00,
                 hcp_pkg::CODE_MAX, 1'b0));
    add_row(row(1'b1, hcp_pkg::CH_CR));
    add_row(trow(1'b1, hcp_pkg::CH_LF, 1'b1, hcp_pkg::KIND_HDRS_DONE, 8'h00,
                 hcp_pkg::CODE_MAX, 1'b0));
    add_row(row(1'b1, "1"));
    add_row(row(1'b1, "z"));
    add_row(row(1'b1, hcp_pkg::CH_CR));
    add_row(trow(1'b1, "q", 1'b1, hcp_pkg::KIND_SIZE_ERR, 8'h00, hcp_pkg::CODE_MAX, 1'b0));
    add_row(row(1'b1, hcp_pkg::CH_LF));
    add_row(trow(1'b1, 8'hAA, 1'b1, hcp_pkg::KIND_CHUNK_BYTE, 8'hAA, hcp_pkg::CODE_MAX,
                 1'b1));
    add_row(row(1'b1, "0"));
    add_row(row(1'b1, hcp_pkg::CH_CR));
    add_row(trow(1'b1, hcp_pkg::CH_LF, 1'b1, hcp_pkg::KIND_COMPLETE, 8'h00,
                 hcp_pkg::CODE_MAX, 1'b0));
    add_row(trow(1'b1, 8'h55, 1'b0, hcp_pkg::KIND_STATUS_BYTE, 8'h00, 10'd0, 1'b0));

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i])
      put_item(dir_rows[i].op, dir_rows[i].data, dir_rows[i].typed, dir_rows[i].has_res,
               dir_rows[i].res);

    write_radix(1'b0);
    while (live_items < 200) send_response();
    wait_all_delivered();
    while (live_items < 260) send_response();

    // The receiver holds off while new items keep coming, so the block backs up.
    write_radix(1'b1);
    hold_req = 1'b1;
    while (live_items < 480) send_response();

    write_radix(1'b0);
    while (live_items < 620) send_response();

    write_radix(1'b1);
    while (live_items < 820) send_response();

    wait_all_delivered();
    repeat (SETTLE_CYCLES * 2) @(posedge clk_i);
    if (err_cnt == 0 && due_results.size() == 0) begin
      $display("** http_response_chunked_parser_unit: PASSED **");
    end else begin
      $display("** http_response_chunked_parser_unit: FAILED **");
    end
    $finish;
  end

endmodule
